[hw/rtl/dcd_pkg.sv]
// dcd_pkg: shared types, constants and the month length function for the
// day count to date converter. No dependencies.
package dcd_pkg;

    localparam int unsigned YEAR_BITS  = 12;
    localparam int unsigned MONTH_BITS = 4;
    localparam int unsigned DAY_BITS   = 5;
    localparam int unsigned YDAYS_BITS = 9;

    localparam logic [YEAR_BITS-1:0]  BASE_YEAR   = 12'd1900;
    // 1900 is 0 mod 4, 0 mod 100 and 300 mod 400.
    localparam logic [1:0]            BASE_MOD4   = 2'd0;
    localparam logic [6:0]            BASE_MOD100 = 7'd0;
    localparam logic [8:0]            BASE_MOD400 = 9'd300;
    localparam logic [6:0]            LAST_MOD100 = 7'd99;
    localparam logic [8:0]            LAST_MOD400 = 9'd399;

    localparam logic [YDAYS_BITS-1:0] DAYS_COMMON = 9'd365;
    localparam logic [YDAYS_BITS-1:0] DAYS_LEAP   = 9'd366;

    localparam logic [MONTH_BITS-1:0] MONTH_JAN = 4'd1;
    localparam logic [MONTH_BITS-1:0] MONTH_FEB = 4'd2;
    localparam logic [MONTH_BITS-1:0] MONTH_APR = 4'd4;
    localparam logic [MONTH_BITS-1:0] MONTH_JUN = 4'd6;
    localparam logic [MONTH_BITS-1:0] MONTH_SEP = 4'd9;
    localparam logic [MONTH_BITS-1:0] MONTH_NOV = 4'd11;
    localparam logic [MONTH_BITS-1:0] MONTH_DEC = 4'd12;

    typedef enum logic [1:0] {
        DCD_IDLE,
        DCD_YEAR,
        DCD_MONTH,
        DCD_DONE
    } dcd_state_t;

    typedef struct packed {
        logic load;
        logic year_step;
        logic month_step;
    } dcd_cmd_t;

    typedef struct packed {
        logic year_done;
        logic month_done;
        logic rem_zero;
    } dcd_status_t;

    function automatic logic [DAY_BITS-1:0] month_len(
        input logic [MONTH_BITS-1:0] m,
        input logic                  leap
    );
        logic [DAY_BITS-1:0] len;
        begin
            if (m == MONTH_FEB)
            begin
                len = leap ? 5'd29 : 5'd28;
            end
            else if (m == MONTH_APR || m == MONTH_JUN || m == MONTH_SEP || m == MONTH_NOV)
            begin
                len = 5'd30;
            end
            else
            begin
                len = 5'd31;
            end
            return len;
        end
    endfunction

endpackage

[hw/rtl/day_count_to_date.sv]
// day_count_to_date: top level of the day count to Gregorian date converter.
// Depends on dcd_pkg, dcd_ctrl and dcd_datapath.
//
//   Channel | Handshake              | Fields
//   --------+------------------------+----------------------------------
//   day     | day_valid / day_stall  | day_count[DAY_COUNT_BITS-1:0]
//   date    | date_valid / date_stall| day_of_month[4:0], month[3:0], year[11:0]
//
// One item is converted at a time. After acceptance the block steps over
// each whole year in the count and then ends the year walk, then steps over
// each whole month (at most eleven) and ends the month walk before it
// presents the result. A zero count skips the month walk. The year walk, one
// compare and subtract per cycle, takes the bulk of the time. A new item is
// taken only after the result has been taken and the controller has returned
// to idle. Reset returns the controller to idle.
// The result holds on the date ports while date_stall is high, and day_stall
// stays high from acceptance until the result has been taken.
module day_count_to_date #(
    parameter int unsigned DAY_COUNT_BITS = 17
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      day_valid,
    output logic                      day_stall,
    input  logic [DAY_COUNT_BITS-1:0] day_count,
    output logic                      date_valid,
    input  logic                      date_stall,
    output logic [4:0]                day_of_month,
    output logic [3:0]                month,
    output logic [11:0]               year
);

    // Command and status between the sequencer and the arithmetic.
    dcd_pkg::dcd_cmd_t    cmd;
    dcd_pkg::dcd_status_t status;

    // The controller walks idle, year, month and done; a zero count skips the
    // month walk and reports day 0 of January 1900.
    dcd_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .day_valid  (day_valid),
        .day_stall  (day_stall),
        .date_valid (date_valid),
        .date_stall (date_stall),
        .status     (status),
        .cmd        (cmd)
    );

    // The datapath keeps the remaining days, the year with its residues
    // mod 4, 100 and 400 for the leap test, and the month.
    dcd_datapath #(
        .DAY_COUNT_BITS (DAY_COUNT_BITS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .day_count    (day_count),
        .cmd          (cmd),
        .status       (status),
        .day_of_month (day_of_month),
        .month        (month),
        .year         (year)
    );

endmodule

[hw/rtl/dcd_datapath.sv]
// dcd_datapath: remainder, year, month and leap tracking registers.
// Depends on dcd_pkg; driven by commands from dcd_ctrl.
module dcd_datapath #(
    parameter int unsigned DAY_COUNT_BITS = 17
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [DAY_COUNT_BITS-1:0]     day_count,
    input  dcd_pkg::dcd_cmd_t             cmd,
    output dcd_pkg::dcd_status_t          status,
    output logic [dcd_pkg::DAY_BITS-1:0]  day_of_month,
    output logic [dcd_pkg::MONTH_BITS-1:0] month,
    output logic [dcd_pkg::YEAR_BITS-1:0] year
);

    logic [DAY_COUNT_BITS-1:0]        rem_reg,    rem_next;
    logic [dcd_pkg::YEAR_BITS-1:0]    year_reg,   year_next;
    logic [dcd_pkg::MONTH_BITS-1:0]   month_reg,  month_next;
    logic [1:0]                       mod4_reg,   mod4_next;
    logic [6:0]                       mod100_reg, mod100_next;
    logic [8:0]                       mod400_reg, mod400_next;

    logic                             leap;
    logic [dcd_pkg::YDAYS_BITS-1:0]   ydays;
    logic [dcd_pkg::DAY_BITS-1:0]     mdays;
    logic [DAY_COUNT_BITS-1:0]        ydays_ext;
    logic [DAY_COUNT_BITS-1:0]        mdays_ext;

    // Year residues are counted alongside the year so the leap test needs no divider.
    assign leap = ((mod4_reg == 2'd0) && (mod100_reg != 7'd0)) || (mod400_reg == 9'd0);
    assign ydays = leap ? dcd_pkg::DAYS_LEAP : dcd_pkg::DAYS_COMMON;
    assign mdays = dcd_pkg::month_len(month_reg, leap);
    assign ydays_ext = DAY_COUNT_BITS'(ydays);
    assign mdays_ext = DAY_COUNT_BITS'(mdays);

    assign status.year_done  = (rem_reg <= ydays_ext);
    assign status.month_done = (month_reg == dcd_pkg::MONTH_DEC) || (rem_reg <= mdays_ext);
    assign status.rem_zero   = (rem_reg == '0);

    always_comb
    begin
        rem_next    = rem_reg;
        year_next   = year_reg;
        month_next  = month_reg;
        mod4_next   = mod4_reg;
        mod100_next = mod100_reg;
        mod400_next = mod400_reg;
        priority if (cmd.load)
        begin
            rem_next    = day_count;
            year_next   = dcd_pkg::BASE_YEAR;
            month_next  = dcd_pkg::MONTH_JAN;
            mod4_next   = dcd_pkg::BASE_MOD4;
            mod100_next = dcd_pkg::BASE_MOD100;
            mod400_next = dcd_pkg::BASE_MOD400;
        end
        else if (cmd.year_step)
        begin
            rem_next    = rem_reg - ydays_ext;
            year_next   = year_reg + 12'd1;
            mod4_next   = mod4_reg + 2'd1;
            mod100_next = (mod100_reg == dcd_pkg::LAST_MOD100) ? 7'd0 : mod100_reg + 7'd1;
            mod400_next = (mod400_reg == dcd_pkg::LAST_MOD400) ? 9'd0 : mod400_reg + 9'd1;
        end
        else if (cmd.month_step)
        begin
            rem_next   = rem_reg - mdays_ext;
            month_next = month_reg + 4'd1;
        end
        else
        begin
            // No command: every register holds its value.
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg    <= '0;
            year_reg   <= dcd_pkg::BASE_YEAR;
            month_reg  <= dcd_pkg::MONTH_JAN;
            mod4_reg   <= dcd_pkg::BASE_MOD4;
            mod100_reg <= dcd_pkg::BASE_MOD100;
            mod400_reg <= dcd_pkg::BASE_MOD400;
        end
        else
        begin
            rem_reg    <= rem_next;
            year_reg   <= year_next;
            month_reg  <= month_next;
            mod4_reg   <= mod4_next;
            mod100_reg <= mod100_next;
            mod400_reg <= mod400_next;
        end
    end

    // Once the month walk ends the remainder is at most 31.
    assign day_of_month = rem_reg[dcd_pkg::DAY_BITS-1:0];
    assign month        = month_reg;
    assign year         = year_reg;

    a_month_range: assert property (@(posedge clk) disable iff (!rst_n)
        (month_reg >= dcd_pkg::MONTH_JAN) && (month_reg <= dcd_pkg::MONTH_DEC))
        else $error("month register left 1..12");

    a_century_mod4: assert property (@(posedge clk) disable iff (!rst_n)
        (mod100_reg == 7'd0) |-> (mod4_reg == 2'd0))
        else $error("mod 4 and mod 100 residues out of step");

    a_quad_century: assert property (@(posedge clk) disable iff (!rst_n)
        (mod400_reg == 9'd0) |-> (mod100_reg == 7'd0))
        else $error("mod 100 and mod 400 residues out of step");

    a_year_step: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.year_step |=> (year_reg == 12'($past(year_reg) + 12'd1)))
        else $error("year did not advance on a year step");

endmodule

[hw/rtl/dcd_ctrl.sv]
// dcd_ctrl: state machine sequencing the year walk and the month walk.
// Depends on dcd_pkg; commands dcd_datapath.
module dcd_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 day_valid,
    output logic                 day_stall,
    output logic                 date_valid,
    input  logic                 date_stall,
    input  dcd_pkg::dcd_status_t status,
    output dcd_pkg::dcd_cmd_t    cmd
);

    dcd_pkg::dcd_state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            dcd_pkg::DCD_IDLE:
            begin
                if (day_valid)
                begin
                    state_next = dcd_pkg::DCD_YEAR;
                end
            end
            dcd_pkg::DCD_YEAR:
            begin
                if (status.year_done)
                begin
                    state_next = status.rem_zero ? dcd_pkg::DCD_DONE : dcd_pkg::DCD_MONTH;
                end
            end
            dcd_pkg::DCD_MONTH:
            begin
                if (status.month_done)
                begin
                    state_next = dcd_pkg::DCD_DONE;
                end
            end
            dcd_pkg::DCD_DONE:
            begin
                if (!date_stall)
                begin
                    state_next = dcd_pkg::DCD_IDLE;
                end
            end
            default:
            begin
                state_next = dcd_pkg::DCD_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd        = '0;
        day_stall  = 1'b1;
        date_valid = 1'b0;
        unique case (state_reg)
            dcd_pkg::DCD_IDLE:
            begin
                day_stall = 1'b0;
                cmd.load  = day_valid;
            end
            dcd_pkg::DCD_YEAR:
            begin
                cmd.year_step = !status.year_done;
            end
            dcd_pkg::DCD_MONTH:
            begin
                cmd.month_step = !status.month_done;
            end
            dcd_pkg::DCD_DONE:
            begin
                date_valid = 1'b1;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= dcd_pkg::DCD_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.load, cmd.year_step, cmd.month_step}))
        else $error("more than one datapath command at once");

    a_month_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == dcd_pkg::DCD_MONTH) |-> !status.rem_zero)
        else $error("month walk entered with a zero count");

    a_done_settled: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == dcd_pkg::DCD_DONE) |->
            (status.year_done && (status.month_done || status.rem_zero)))
        else $error("result presented before both walks finished");

endmodule
